// File: src/ecu_pkg.sv
// ----------------------------------------------------------------------------
// ecu_pkg: shared types and constants of the easing curve unit
// Fixed point formats, curve codes, cosine polynomial coefficients and the
// layout of the word that travels down the pipeline.
// ----------------------------------------------------------------------------
package ecu_pkg;

    // Fixed point format: ONE = 2^FRAC_BITS stands for 1.0
    localparam int FRAC_BITS = 16;
    localparam int VW        = FRAC_BITS + 1;       // value width
    localparam int RB        = FRAC_BITS + 2;       // root result bits
    localparam int TW        = 3 * FRAC_BITS + 4;   // root target width
    localparam int NW        = 2 * FRAC_BITS + 1;   // divider operand width
    localparam int DIV_STEPS = FRAC_BITS + 2;       // quotient bits

    localparam logic [VW-1:0] ONE    = VW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] HALF   = VW'(1) << (FRAC_BITS - 1);
    localparam logic [NW-1:0] ONE_SQ = NW'(1) << (2 * FRAC_BITS);
    localparam logic [31:0]   Q30_ONE = 32'(1) << 30;

    // Pipeline stage map
    localparam int ST_PREP   = 1;
    localparam int ST_ROOT0  = 2;
    localparam int ST_POST   = ST_ROOT0 + RB;
    localparam int ST_DIV0   = ST_POST + 1;
    localparam int ST_LAST   = ST_DIV0 + DIV_STEPS;
    localparam int NUM_STAGES = ST_LAST + 1;

    // Direction codes
    localparam logic KIND_FWD = 1'b0;
    localparam logic KIND_INV = 1'b1;

    // Curve codes
    localparam logic [2:0] CRV_LINEAR    = 3'd0;
    localparam logic [2:0] CRV_QUAD_IN   = 3'd1;
    localparam logic [2:0] CRV_CUBIC_IN  = 3'd2;
    localparam logic [2:0] CRV_QUAD_OUT  = 3'd3;
    localparam logic [2:0] CRV_CUBIC_OUT = 3'd4;
    localparam logic [2:0] CRV_COSINE    = 3'd5;
    localparam logic [2:0] CRV_RATIONAL  = 3'd6;

    // Odd polynomial for sin(pi*t/2) in Q30
    localparam logic [31:0] COS_C1 = 32'd1686629713;
    localparam logic [31:0] COS_C3 = 32'd693598669;
    localparam logic [31:0] COS_C5 = 32'd85569306;
    localparam logic [31:0] COS_C7 = 32'd5026995;
    localparam logic [31:0] COS_C9 = 32'd172272;

    // Horner coefficient for step j, highest order first
    function automatic logic [31:0] cos_coef(input int j);
        logic [31:0] c;
        case (j)
            0: c = COS_C7;
            1: c = COS_C5;
            2: c = COS_C3;
            default: c = COS_C1;
        endcase
        return c;
    endfunction

    // One word in flight
    typedef struct packed {
        logic          vld;
        logic          kind;
        logic [2:0]    curve;
        logic [VW-1:0] v;        // clamped input
        logic [VW-1:0] pa;       // polynomial operand
        logic [VW-1:0] pm;       // polynomial partial product
        logic [29:0]   t;        // cosine argument, Q30
        logic [28:0]   t2;       // its square, Q30
        logic [31:0]   cp;       // cosine accumulator, Q30
        logic          cube;     // root mode
        logic [RB-1:0]   m;
        logic [2*RB-1:0] m2;
        logic [3*RB-1:0] m3;
        logic [TW-1:0]   tgt;
        logic          use_div;
        logic [NW-1:0] num;
        logic [NW-1:0] den;
        logic [RB-1:0] q;
        logic [NW:0]   rem;
        logic [VW-1:0] res;
    } t_item;

endpackage

// File: src/easing_curve_unit.sv
// Throughput: one word per clock unless the output stalls; the root unit
// (FRAC_BITS+2 steps) and the divider (FRAC_BITS+2 steps) are fully
// pipelined, one bit per stage.
// A stall on the output freezes the whole pipeline and holds o_stall high.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// easing_curve_unit: pipelined easing curve evaluator
// Evaluates seven easing curves, and the inverses of all but cosine, in
// unsigned fixed point; square and cube roots, rational divide bit-serial.
// ----------------------------------------------------------------------------
module easing_curve_unit
    import ecu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_kind,
    input  logic [2:0]    i_curve,
    input  logic [VW-1:0] i_value,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [VW-1:0] o_result
);

    t_item r_pipe [NUM_STAGES];
    logic  adv;

    // Advance unless the output word is held
    assign adv      = !(r_pipe[ST_LAST].vld && i_stall);
    assign o_stall  = !adv;
    assign o_valid  = r_pipe[ST_LAST].vld;
    assign o_result = r_pipe[ST_LAST].res;

    // Capture and clamp the input word
    t_item n_in;
    always_comb begin
        n_in       = '0;
        n_in.vld   = i_valid;
        n_in.kind  = i_kind;
        n_in.curve = i_curve;
        n_in.v     = (i_value > ONE) ? ONE : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe[0].vld <= 1'b0;
        end else if (adv) begin
            r_pipe[0] <= n_in;
        end
    end

    for (genvar i = 1; i < NUM_STAGES; i++) begin : g_stage
        t_item n_stg;

        if (i == ST_PREP) begin : g_prep
            // Set up products, root target and divider operands
            always_comb begin
                logic [VW-1:0]   omv, a, u, w;
                logic [2*VW-1:0] sq, vv, vo;
                logic [29:0]     t;
                logic [59:0]     tt;
                n_stg = r_pipe[i-1];
                omv = ONE - r_pipe[i-1].v;
                a   = (r_pipe[i-1].curve == CRV_QUAD_OUT ||
                       r_pipe[i-1].curve == CRV_CUBIC_OUT) ? omv : r_pipe[i-1].v;
                w   = a;
                sq  = a * a;
                n_stg.pa = a;
                n_stg.pm = VW'((sq + (2*VW)'(HALF)) >> FRAC_BITS);
                u   = (r_pipe[i-1].v <= HALF) ? r_pipe[i-1].v : omv;
                t   = 30'(u) << (30 - FRAC_BITS);
                tt  = t * t;
                n_stg.t  = t;
                n_stg.t2 = 29'(tt >> 30);
                vv  = r_pipe[i-1].v * r_pipe[i-1].v;
                vo  = r_pipe[i-1].v * omv;
                n_stg.num = NW'(vv);
                n_stg.den = ONE_SQ - {vo[NW-2:0], 1'b0};
                n_stg.cube = (r_pipe[i-1].curve == CRV_CUBIC_IN ||
                              r_pipe[i-1].curve == CRV_CUBIC_OUT);
                if (r_pipe[i-1].curve == CRV_RATIONAL) begin
                    n_stg.tgt = TW'(vo) << 2;
                end else if (n_stg.cube) begin
                    n_stg.tgt = TW'(w) << (2 * FRAC_BITS + 3);
                end else begin
                    n_stg.tgt = TW'(w) << (FRAC_BITS + 2);
                end
                n_stg.m  = '0;
                n_stg.m2 = '0;
                n_stg.m3 = '0;
                n_stg.use_div = (r_pipe[i-1].curve == CRV_RATIONAL);
            end
        end else if (i < ST_POST) begin : g_root
            localparam int J = i - ST_ROOT0;
            localparam int K = RB - 1 - J;
            // Try one root bit; run cubic and cosine products alongside
            always_comb begin
                logic [RB-1:0]   c;
                logic [2*RB-1:0] c2;
                logic [3*RB-1:0] c3, m2x3, m1x3;
                logic            ok;
                logic [2*VW-1:0] pr;
                logic [63:0]     cpr;
                logic [31:0]     prev;
                n_stg = r_pipe[i-1];
                c    = r_pipe[i-1].m | (RB'(1) << K);
                c2   = r_pipe[i-1].m2 + ((2*RB)'(r_pipe[i-1].m) << (K + 1))
                       + ((2*RB)'(1) << (2 * K));
                m2x3 = ((3*RB)'(r_pipe[i-1].m2) << 1) + (3*RB)'(r_pipe[i-1].m2);
                m1x3 = ((3*RB)'(r_pipe[i-1].m) << 1) + (3*RB)'(r_pipe[i-1].m);
                c3   = r_pipe[i-1].m3 + (m2x3 << K) + (m1x3 << (2 * K))
                       + ((3*RB)'(1) << (3 * K));
                ok   = r_pipe[i-1].cube ? (c3 <= (3*RB)'(r_pipe[i-1].tgt))
                                        : (TW'(c2) <= r_pipe[i-1].tgt);
                if (ok) begin
                    n_stg.m  = c;
                    n_stg.m2 = c2;
                    n_stg.m3 = c3;
                end

                // Second product of the cubic curves
                pr = r_pipe[i-1].pm * r_pipe[i-1].pa;
                if (J == 0 && (r_pipe[i-1].curve == CRV_CUBIC_IN ||
                               r_pipe[i-1].curve == CRV_CUBIC_OUT)) begin
                    n_stg.pm = VW'((pr + (2*VW)'(HALF)) >> FRAC_BITS);
                end

                // Cosine: Horner steps, then sine and its square
                prev = (J == 0) ? COS_C9 : r_pipe[i-1].cp;
                cpr  = '0;
                if (J < 4) begin
                    cpr = 64'(prev) * 64'(r_pipe[i-1].t2);
                    n_stg.cp = cos_coef(J) - 32'(cpr >> 30);
                end else if (J == 4) begin
                    cpr = 64'(r_pipe[i-1].cp) * 64'(r_pipe[i-1].t);
                    n_stg.cp = ((cpr >> 30) > 64'(Q30_ONE)) ? Q30_ONE : 32'(cpr >> 30);
                end else if (J == 5) begin
                    cpr = 64'(r_pipe[i-1].cp) * 64'(r_pipe[i-1].cp);
                    n_stg.cp = 32'(cpr >> 30);
                end
            end
        end else if (i == ST_POST) begin : g_post
            // Round roots and cosine, pick the result or load the divider
            always_comb begin
                logic [VW-1:0] rt, cosr;
                n_stg = r_pipe[i-1];
                rt   = VW'(((RB+1)'(r_pipe[i-1].m) + (RB+1)'(1)) >> 1);
                cosr = VW'((r_pipe[i-1].cp + (32'(1) << (29 - FRAC_BITS)))
                           >> (30 - FRAC_BITS));
                n_stg.res = r_pipe[i-1].v;
                if (r_pipe[i-1].kind == KIND_FWD) begin
                    case (r_pipe[i-1].curve)
                        CRV_QUAD_IN, CRV_CUBIC_IN:   n_stg.res = r_pipe[i-1].pm;
                        CRV_QUAD_OUT, CRV_CUBIC_OUT: n_stg.res = ONE - r_pipe[i-1].pm;
                        CRV_COSINE: n_stg.res = (r_pipe[i-1].v <= HALF) ? cosr
                                                                        : ONE - cosr;
                        default: n_stg.res = r_pipe[i-1].v;
                    endcase
                end else begin
                    case (r_pipe[i-1].curve)
                        CRV_QUAD_IN, CRV_CUBIC_IN:   n_stg.res = rt;
                        CRV_QUAD_OUT, CRV_CUBIC_OUT: n_stg.res = ONE - rt;
                        CRV_RATIONAL: begin
                            n_stg.num = NW'(r_pipe[i-1].v);
                            n_stg.den = NW'(r_pipe[i-1].v) + NW'(rt);
                        end
                        default: n_stg.res = r_pipe[i-1].v;
                    endcase
                end
                n_stg.q   = '0;
                n_stg.rem = (NW+1)'(n_stg.num);
            end
        end else if (i < ST_LAST) begin : g_div
            localparam int J = i - ST_DIV0;
            // One restoring divide step
            always_comb begin
                logic [NW:0]   r;
                logic [RB-1:0] q;
                n_stg = r_pipe[i-1];
                r = r_pipe[i-1].rem;
                q = r_pipe[i-1].q;
                if (J > 0) begin
                    r = r << 1;
                    q = q << 1;
                end
                if (r >= (NW+1)'(r_pipe[i-1].den)) begin
                    q[0] = 1'b1;
                    r    = r - (NW+1)'(r_pipe[i-1].den);
                end
                n_stg.rem = r;
                n_stg.q   = q;
            end
        end else begin : g_last
            // Round the quotient and saturate
            always_comb begin
                logic [VW-1:0] rs;
                n_stg = r_pipe[i-1];
                rs = r_pipe[i-1].res;
                if (r_pipe[i-1].use_div) begin
                    if (r_pipe[i-1].kind == KIND_INV && r_pipe[i-1].v == '0) begin
                        rs = '0;
                    end else begin
                        rs = VW'(((RB+1)'(r_pipe[i-1].q) + (RB+1)'(1)) >> 1);
                    end
                end
                n_stg.res = (rs > ONE) ? ONE : rs;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pipe[i].vld <= 1'b0;
            end else if (adv) begin
                r_pipe[i] <= n_stg;
            end
        end
    end

endmodule

// File: src/ecu_checker.sv
// ----------------------------------------------------------------------------
// ecu_checker: port level checks of the easing curve unit
// Watches the handshakes and the result range from the top level ports.
// ----------------------------------------------------------------------------
module ecu_checker
    import ecu_pkg::*;
(
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          i_kind,
    input logic [2:0]    i_curve,
    input logic [VW-1:0] i_value,
    input logic          o_valid,
    input logic          i_stall,
    input logic [VW-1:0] o_result
);

    // Result never leaves [0, 1]
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result <= ONE)
        else $error("result above one");

    // Input stalls only behind a held output word
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back pressure");

    // Held output word does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result)))
        else $error("held output word changed");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind easing_curve_unit ecu_checker u_ecu_checker (.*);
